>>> hw/rtl/rstc_pkg.sv
// shared constants, types and helper functions for the raster smoothing block
`timescale 1ns / 1ps
`default_nettype none

package rstc_pkg;

   // sizing
   localparam int MAX_WIDTH   = 2048;
   localparam int HEIGHT_BITS = 9;
   localparam int RING_DEPTH  = MAX_WIDTH + 1;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int EW_W        = $clog2(MAX_WIDTH + 1);
   localparam int HELD_W      = $clog2(MAX_WIDTH + 2);
   localparam int CFG_W       = 12;
   localparam int ROW_W       = CFG_W;
   localparam int LIMIT_W     = 9;
   localparam int CLASS_W     = 3;
   localparam int MIN_DIM     = 3;
   localparam int CMP_W       = (HEIGHT_BITS > LIMIT_W) ? HEIGHT_BITS : LIMIT_W;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = CFG_W;

   // five point sum and divide by five through a reciprocal multiply
   localparam int PART_W    = HEIGHT_BITS + 2;
   localparam int SUM_W     = HEIGHT_BITS + 3;
   localparam int DIV_SHIFT = SUM_W + 2;
   localparam int DIV_MULT  = (2 ** DIV_SHIFT) / 5 + 1;
   localparam int PROD_W    = SUM_W + DIV_SHIFT;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEEP_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SHALLOW_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAND_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MOUNTAIN_LIMIT = 3'd5;

   // terrain classes
   localparam logic [CLASS_W-1:0] CLASS_DEEP     = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_SHALLOW  = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_LAND     = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_MOUNTAIN = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_PEAK     = 3'd4;

   // reset values
   localparam logic [CFG_W-1:0]   FRAME_DIM_RESET      = 12'd2048;
   localparam logic [LIMIT_W-1:0] DEEP_LIMIT_RESET     = 9'd139;
   localparam logic [LIMIT_W-1:0] SHALLOW_LIMIT_RESET  = 9'd156;
   localparam logic [LIMIT_W-1:0] LAND_LIMIT_RESET     = 9'd225;
   localparam logic [LIMIT_W-1:0] MOUNTAIN_LIMIT_RESET = 9'd260;

   typedef logic [HEIGHT_BITS-1:0] height_type;
   typedef logic [COL_W-1:0]       col_type;
   typedef logic [ROW_W-1:0]       row_type;
   typedef logic [EW_W-1:0]        ew_type;
   typedef logic [HELD_W-1:0]      held_type;
   typedef logic [RING_AW-1:0]     ring_addr_type;
   typedef logic [LIMIT_W-1:0]     limit_type;
   typedef logic [CLASS_W-1:0]     class_type;
   typedef logic [PART_W-1:0]      part_type;

   // scheduler to filter, valid once per released result
   typedef struct packed {
      logic       valid;
      logic       smooth;
      logic       last;
      col_type    col;
      height_type south;
   } b_ctl_type;

   // filter internal stage
   typedef struct packed {
      logic       valid;
      logic       smooth;
      logic       last;
      col_type    col;
      part_type   partial;
      height_type center;
   } c_ctl_type;

   // filter to output queue
   typedef struct packed {
      logic       valid;
      height_type height;
      logic       last;
   } res_type;

   typedef struct packed {
      height_type height;
      class_type  terrain;
      logic       last;
   } fifo_entry_type;

   // ring slot that lies back places before the write slot
   function automatic ring_addr_type ring_addr(ring_addr_type wp, held_type back);
      logic [HELD_W:0] diff;
      diff = (HELD_W + 1)'(wp) - (HELD_W + 1)'(back);
      if (diff[HELD_W]) begin
         diff = diff + (HELD_W + 1)'(RING_DEPTH);
      end
      return diff[RING_AW-1:0];
   endfunction

   // height thresholds to terrain class
   function automatic class_type classify(height_type h, limit_type deep, limit_type shallow,
                                          limit_type land, limit_type mountain);
      logic [CMP_W-1:0] hv;
      class_type        c;
      hv = CMP_W'(h);
      if (hv < CMP_W'(deep)) begin
         c = CLASS_DEEP;
      end else if (hv < CMP_W'(shallow)) begin
         c = CLASS_SHALLOW;
      end else if (hv < CMP_W'(land)) begin
         c = CLASS_LAND;
      end else if (hv < CMP_W'(mountain)) begin
         c = CLASS_MOUNTAIN;
      end else begin
         c = CLASS_PEAK;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rstc_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface rstc_req_if;
   import rstc_pkg::*;

   logic       valid;
   logic       ready;
   logic       kind;
   height_type height_in;

   modport source (output valid, output kind, output height_in, input ready);
   modport sink   (input valid, input kind, input height_in, output ready);
endinterface

interface rstc_rsp_if;
   import rstc_pkg::*;

   logic       valid;
   logic       ready;
   height_type height_out;
   class_type  terrain_class;
   logic       last_of_frame;

   modport source (output valid, output height_out, output terrain_class,
                   output last_of_frame, input ready);
   modport sink   (input valid, input height_out, input terrain_class,
                   input last_of_frame, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rstc_ram.sv
// generic single write, single registered read memory
`timescale 1ns / 1ps
`default_nettype none

module rstc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rstc_sched.sv
// request scheduler: ring pointers, held count, output position and memory addresses
`timescale 1ns / 1ps
`default_nettype none

module rstc_sched (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   kind,
   input  wire rstc_pkg::height_type   height_in,
   input  wire rstc_pkg::ew_type       eff_width,
   input  wire rstc_pkg::row_type      eff_height,
   output logic                        emit_now,
   output rstc_pkg::ring_addr_type     center_addr,
   output rstc_pkg::ring_addr_type     east_addr,
   output logic                        ring_wr_en,
   output rstc_pkg::ring_addr_type     ring_wr_addr,
   output rstc_pkg::height_type        ring_wr_data,
   output rstc_pkg::col_type           north_addr,
   output rstc_pkg::b_ctl_type         stage_b
);
   import rstc_pkg::*;

   held_type      held_ff, held_in;
   ring_addr_type wp_ff, wp_in;
   col_type       col_ff, col_in;
   row_type       row_ff, row_in;
   height_type    south_ff;
   b_ctl_type     b_ff, b_in;

   logic            is_pixel, is_flush, full_now, inner, last_px;
   held_type        w_held, back_a;
   logic [EW_W:0]   col_next;
   logic [ROW_W:0]  row_next;

   // decode the request
   always_comb begin
      is_pixel = accept && (kind == KIND_PIXEL);
      is_flush = accept && (kind == KIND_FLUSH);
      w_held   = HELD_W'(eff_width) + HELD_W'(1);
      full_now = held_ff >= w_held;
      emit_now = (is_pixel && full_now) || (is_flush && (held_ff != '0));
   end

   // ring read addresses: center and east neighbor, plus the north row address
   always_comb begin
      back_a      = (kind == KIND_PIXEL) ? w_held : held_ff;
      center_addr = ring_addr(wp_ff, back_a);
      east_addr   = ring_addr(wp_ff, HELD_W'(eff_width));
      north_addr  = col_ff;
   end

   // ring write of the incoming pixel
   always_comb begin
      ring_wr_en   = is_pixel;
      ring_wr_addr = wp_ff;
      ring_wr_data = height_in;
   end

   // output position flags
   always_comb begin
      col_next = (EW_W + 1)'(col_ff) + (EW_W + 1)'(1);
      row_next = (ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1);
      inner    = (row_ff != '0) && (row_next < (ROW_W + 1)'(eff_height))
                 && (col_ff != '0) && (col_next < (EW_W + 1)'(eff_width));
      last_px  = (row_next >= (ROW_W + 1)'(eff_height))
                 && (col_next >= (EW_W + 1)'(eff_width));
   end

   // next state
   always_comb begin
      held_in = held_ff;
      wp_in   = wp_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (is_pixel) begin
         held_in = full_now ? w_held : held_ff + HELD_W'(1);
         wp_in   = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + RING_AW'(1);
      end else if (is_flush && (held_ff != '0)) begin
         held_in = held_ff - HELD_W'(1);
      end
      if (emit_now) begin
         if (col_next >= (EW_W + 1)'(eff_width)) begin
            col_in = '0;
            row_in = (row_next >= (ROW_W + 1)'(eff_height)) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
      b_in.valid  = emit_now;
      b_in.smooth = is_pixel && full_now && inner;
      b_in.last   = last_px;
      b_in.col    = col_ff;
      b_in.south  = south_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         wp_ff   <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         b_ff    <= '0;
      end else begin
         held_ff <= held_in;
         wp_ff   <= wp_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         b_ff    <= b_in;
      end
   end

   // most recent pixel, the south neighbor of the next output
   always_ff @(posedge clock) begin
      if (is_pixel) begin
         south_ff <= height_in;
      end
   end

   assign stage_b = b_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rstc_filter.sv
// five point average with the smoothed previous row and west value
`timescale 1ns / 1ps
`default_nettype none

module rstc_filter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rstc_pkg::b_ctl_type   stage_b,
   input  wire rstc_pkg::height_type  center_q,
   input  wire rstc_pkg::height_type  east_q,
   input  wire rstc_pkg::col_type     north_addr,
   output rstc_pkg::res_type          result
);
   import rstc_pkg::*;

   height_type        north_q;
   c_ctl_type         c_ff, c_in;
   height_type        west_ff;
   res_type           res_ff, res_in;
   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] prod;
   height_type        v;

   // smoothed previous row, written back as each result leaves
   rstc_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_prev_row (
      .clock   (clock),
      .wr_en   (c_ff.valid),
      .wr_addr (c_ff.col),
      .wr_data (v),
      .rd_addr (north_addr),
      .rd_data (north_q)
   );

   // stage b: sum of the center and the three neighbors known up front
   always_comb begin
      c_in.valid   = stage_b.valid;
      c_in.smooth  = stage_b.smooth;
      c_in.last    = stage_b.last;
      c_in.col     = stage_b.col;
      c_in.partial = PART_W'(north_q) + PART_W'(stage_b.south)
                     + PART_W'(east_q) + PART_W'(center_q);
      c_in.center  = center_q;
   end

   // stage c: add west, divide by five through reciprocal multiply, or pass the center when not smoothing
   always_comb begin
      sum  = SUM_W'(c_ff.partial) + SUM_W'(west_ff);
      prod = PROD_W'(sum) * PROD_W'(DIV_MULT);
      v    = c_ff.smooth ? prod[DIV_SHIFT +: HEIGHT_BITS] : c_ff.center;
      res_in.valid  = c_ff.valid;
      res_in.height = v;
      res_in.last   = c_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff    <= '0;
         res_ff  <= '0;
         west_ff <= '0;
      end else begin
         c_ff   <= c_in;
         res_ff <= res_in;
         if (c_ff.valid) begin
            west_ff <= v;
         end
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rstc_out.sv
// terrain classification, response queue and request credit
`timescale 1ns / 1ps
`default_nettype none

module rstc_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rstc_pkg::res_type     result,
   input  wire rstc_pkg::limit_type   deep_limit,
   input  wire rstc_pkg::limit_type   shallow_limit,
   input  wire rstc_pkg::limit_type   land_limit,
   input  wire rstc_pkg::limit_type   mountain_limit,
   input  wire logic                  emit_now,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rstc_pkg::height_type       height_out,
   output rstc_pkg::class_type        terrain_class,
   output logic                       last_of_frame
);
   import rstc_pkg::*;

   fifo_entry_type     fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]   pending_ff, pending_in;
   fifo_entry_type     push_entry, head;
   logic               pop;

   // classify the result on its way into the queue
   always_comb begin
      push_entry.height  = result.height;
      push_entry.terrain = classify(result.height, deep_limit, shallow_limit,
                                    land_limit, mountain_limit);
      push_entry.last    = result.last;
   end

   // queue pointers and the count of results owed
   always_comb begin
      rsp_valid = wr_ptr_ff != rd_ptr_ff;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = result.valid ? wr_ptr_ff + (FIFO_AW + 1)'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + (FIFO_AW + 1)'(1) : rd_ptr_ff;
      case ({emit_now, pop})
         2'b10:   pending_in = pending_ff + (FIFO_AW + 1)'(1);
         2'b01:   pending_in = pending_ff - (FIFO_AW + 1)'(1);
         default: pending_in = pending_ff;
      endcase
      req_ready = pending_ff < (FIFO_AW + 1)'(FIFO_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         pending_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         pending_ff <= pending_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (result.valid) begin
         fifo_ff[wr_ptr_ff[FIFO_AW-1:0]] <= push_entry;
      end
   end

   // head of queue drives the response
   always_comb begin
      head          = fifo_ff[rd_ptr_ff[FIFO_AW-1:0]];
      height_out    = head.height;
      terrain_class = head.terrain;
      last_of_frame = head.last;
   end

endmodule

`default_nettype wire

>>> hw/rtl/raster_smoothing_and_terrain_class.sv
// Raster smoothing and terrain class block, top level.
//
// Requests arrive on req_chan: kind 0 carries the next original height of the
// raster in row order, kind 1 asks for one held result to be drained. Each
// pixel is answered frame_width + 1 pixels later, when the pixel below-right
// of it arrives, or by a flush at the end of the stream. Results leave on
// rsp_chan with the smoothed height, its terrain class and a last-of-frame mark.
// A released result passes the scheduler, stage c and result registers and the
// queue before it reaches rsp_chan. Throughput: one request per cycle while
// req_chan is ready; the ring of original pixels is held twice so that center
// and east are read in the same cycle, and the smoothed row memory is read and
// written back once per result. The divide by five is a reciprocal multiply in
// the west loop. When rsp_chan stalls, results collect in an eight entry queue;
// req_chan stays ready while fewer than eight results are owed, then holds off.
// Reset (synchronous, active high) empties the pipeline and queue, clears the
// counters and restores the csr defaults; the memories are not cleared and
// there is no start-up pass. The user must write CSRs, via csr_wr_en, csr_index
// and csr_wr_data, only while no request is in flight; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module raster_smoothing_and_terrain_class (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rstc_req_if.sink                                req_chan,
   rstc_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [rstc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rstc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import rstc_pkg::*;

   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   limit_type        deep_limit_ff, shallow_limit_ff, land_limit_ff, mountain_limit_ff;
   ew_type           eff_width;
   row_type          eff_height;

   logic             accept, emit_now, req_ready;
   ring_addr_type    center_addr, east_addr, ring_wr_addr;
   logic             ring_wr_en;
   height_type       ring_wr_data, center_q, east_q;
   col_type          north_addr;
   b_ctl_type        stage_b;
   res_type          result;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= FRAME_DIM_RESET;
         frame_height_ff   <= FRAME_DIM_RESET;
         deep_limit_ff     <= DEEP_LIMIT_RESET;
         shallow_limit_ff  <= SHALLOW_LIMIT_RESET;
         land_limit_ff     <= LAND_LIMIT_RESET;
         mountain_limit_ff <= MOUNTAIN_LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:    frame_width_ff    <= csr_wr_data[CFG_W-1:0];
            REG_FRAME_HEIGHT:   frame_height_ff   <= csr_wr_data[CFG_W-1:0];
            REG_DEEP_LIMIT:     deep_limit_ff     <= csr_wr_data[LIMIT_W-1:0];
            REG_SHALLOW_LIMIT:  shallow_limit_ff  <= csr_wr_data[LIMIT_W-1:0];
            REG_LAND_LIMIT:     land_limit_ff     <= csr_wr_data[LIMIT_W-1:0];
            REG_MOUNTAIN_LIMIT: mountain_limit_ff <= csr_wr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp frame size to the supported range
   always_comb begin
      if (int'(frame_width_ff) < MIN_DIM) begin
         eff_width = EW_W'(MIN_DIM);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         eff_width = EW_W'(MAX_WIDTH);
      end else begin
         eff_width = EW_W'(frame_width_ff);
      end
      eff_height = (int'(frame_height_ff) < MIN_DIM) ? ROW_W'(MIN_DIM) : frame_height_ff;
   end

   // request handshake
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   rstc_sched u_sched (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_chan.kind),
      .height_in    (req_chan.height_in),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .emit_now     (emit_now),
      .center_addr  (center_addr),
      .east_addr    (east_addr),
      .ring_wr_en   (ring_wr_en),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .north_addr   (north_addr),
      .stage_b      (stage_b)
   );

   // original pixel ring, center copy
   rstc_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring_center (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr (center_addr),
      .rd_data (center_q)
   );

   // original pixel ring, east copy
   rstc_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring_east (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_addr (east_addr),
      .rd_data (east_q)
   );

   rstc_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .stage_b    (stage_b),
      .center_q   (center_q),
      .east_q     (east_q),
      .north_addr (north_addr),
      .result     (result)
   );

   rstc_out u_out (
      .clock          (clock),
      .reset          (reset),
      .result         (result),
      .deep_limit     (deep_limit_ff),
      .shallow_limit  (shallow_limit_ff),
      .land_limit     (land_limit_ff),
      .mountain_limit (mountain_limit_ff),
      .emit_now       (emit_now),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .height_out     (rsp_chan.height_out),
      .terrain_class  (rsp_chan.terrain_class),
      .last_of_frame  (rsp_chan.last_of_frame)
   );

endmodule

`default_nettype wire
